// ===== design/apts_pkg.sv =====
// Shared types, widths, register codes and saturating helpers for the
// ABBA paired timing statistics block. No dependencies.
package apts_pkg;

  localparam int TICK_W     = 24;
  localparam int FRAME_W    = 32;
  localparam int SUM_W      = 64;
  localparam int SQ_W       = 2 * TICK_W;
  localparam int DIFF_W     = TICK_W + 2;
  localparam int MAG_W      = DIFF_W - 1;
  localparam int DSQ_W      = 2 * MAG_W;
  localparam int WARM_W     = 8;
  localparam int NUM_ARMS   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  localparam logic [WARM_W-1:0] WARMUP_RESET = 8'd30;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 2'd2;

  // Per-arm statistics word kept in the stats RAM
  typedef struct packed {
    logic [FRAME_W-1:0] frames;
    logic [SUM_W-1:0]   total;
    logic [SUM_W-1:0]   sq_total;
  } arm_stats_t;

  localparam int STATS_W = $bits(arm_stats_t);

  // Item as registered by the front stage
  typedef struct packed {
    logic                     en;
    logic                     arm;
    logic                     next_arm;
    logic                     counted;
    logic                     done;
    logic [TICK_W-1:0]        ticks;
    logic [SQ_W-1:0]          ticks_sq;
    logic signed [DIFF_W-1:0] diff;
  } item_t;

  // One result beat
  typedef struct packed {
    logic                     arm_used;
    logic                     next_arm;
    logic                     counted;
    arm_stats_t               stats;
    logic                     group_done;
    logic signed [DIFF_W-1:0] group_diff_doubled;
    logic [FRAME_W-1:0]       group_count;
    logic signed [SUM_W-1:0]  group_diff_total;
    logic [SUM_W-1:0]         group_diff_square_total;
  } result_t;

  // ABBA arm of a frame number
  function automatic logic arm_of(input logic [FRAME_W-1:0] f, input logic swap);
    return f[0] ^ f[1] ^ swap;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add_u(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [FRAME_W-1:0] sat_inc(input logic [FRAME_W-1:0] a);
    return (a == '1) ? a : a + FRAME_W'(1);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add_s(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      return a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== design/apts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module apts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/apts_front.sv =====
// Accept stage: frame counter, ABBA arm choice, warmup check, group buffer
// and paired difference, squared duration. Depends on apts_pkg.
module apts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [apts_pkg::TICK_W-1:0]   frame_ticks,
  input  logic                          enable,
  input  logic                          swap_arms,
  input  logic [apts_pkg::WARM_W-1:0]   warmup_groups,
  output logic                          rd_arm,
  output logic                          a_valid,
  output apts_pkg::item_t               a_item
);
  import apts_pkg::*;

  logic [FRAME_W-1:0]       frame_index;
  logic [FRAME_W-1:0]       frame_inc;
  logic [FRAME_W-1:0]       warm_frames;
  logic [TICK_W-1:0]        gbuf [4];
  logic [1:0]               slot;
  logic                     cur_arm;
  logic                     cnt;
  logic                     last;
  logic [DIFF_W-1:0]        mid;
  logic [DIFF_W-1:0]        outer;
  item_t                    item_next;

  // Decode the current frame
  always_comb begin
    frame_inc   = frame_index + FRAME_W'(1);
    warm_frames = {{(FRAME_W-WARM_W-2){1'b0}}, warmup_groups, 2'b00};
    slot        = frame_index[1:0];
    cur_arm     = arm_of(frame_index, swap_arms);
    cnt         = enable && (frame_index >= warm_frames);
    last        = cnt && (slot == 2'd3);
    mid         = {2'b00, gbuf[1]} + {2'b00, gbuf[2]};
    outer       = {2'b00, gbuf[0]} + {2'b00, frame_ticks};
    rd_arm      = enable ? cur_arm : 1'b0;

    item_next.en       = enable;
    item_next.arm      = rd_arm;
    item_next.next_arm = enable ? arm_of(frame_inc, swap_arms) : 1'b0;
    item_next.counted  = cnt;
    item_next.done     = last;
    item_next.ticks    = frame_ticks;
    item_next.ticks_sq = {{TICK_W{1'b0}}, frame_ticks} * {{TICK_W{1'b0}}, frame_ticks};
    item_next.diff     = last ? $signed(mid - outer) : '0;
  end

  // Advance frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
      a_valid     <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept && enable) begin
        frame_index <= frame_inc;
      end
    end
  end

  // Hold item payload and group buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item_next;
      if (cnt) begin
        gbuf[slot] <= frame_ticks;
      end
    end
  end

  a_done_counted: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_item.done |-> a_item.counted)
    else $error("group completion on an uncounted frame");

  a_idle_arm: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_item.en |-> !a_item.counted && !a_item.arm && !a_item.next_arm)
    else $error("disabled frame touched an arm");

endmodule

// ===== design/apts_accum.sv =====
// Accumulate stages: per-arm stats read-modify-write on the stats RAM with
// a one-beat bypass, then paired-difference sums. Depends on apts_pkg, apts_ram.
module apts_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic              rd_arm,
  input  logic              a_valid,
  input  apts_pkg::item_t   a_item,
  output logic              push_valid,
  output apts_pkg::result_t push_data
);
  import apts_pkg::*;

  logic [NUM_ARMS-1:0]      arm_vld;
  logic                     rd_vld;
  arm_stats_t               rd_data;
  logic                     byp_valid;
  logic                     byp_arm;
  arm_stats_t               byp_data;
  arm_stats_t               stats_old;
  arm_stats_t               stats_new;
  arm_stats_t               stats_out;
  logic                     wr_en;
  logic signed [SUM_W-1:0]  paired_sum;
  logic signed [SUM_W-1:0]  paired_sum_next;
  logic [FRAME_W-1:0]       paired_groups;
  logic [FRAME_W-1:0]       paired_groups_next;
  logic [SUM_W-1:0]         paired_sq_sum;
  logic [SUM_W-1:0]         paired_sq_sum_next;
  logic [DIFF_W-1:0]        diff_neg;
  logic [MAG_W-1:0]         mag;
  logic                     c_valid;
  result_t                  c_res;
  logic [DSQ_W-1:0]         c_dsq;

  apts_ram #(
    .WIDTH (STATS_W),
    .DEPTH (NUM_ARMS)
  ) u_stats_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (a_item.arm),
    .wr_data (stats_new),
    .rd_en   (rd_en),
    .rd_addr (rd_arm),
    .rd_data (rd_data)
  );

  // Pick newest arm stats and update them
  always_comb begin
    wr_en = a_valid && a_item.counted;
    if (byp_valid && (byp_arm == a_item.arm)) begin
      stats_old = byp_data;
    end else if (rd_vld) begin
      stats_old = rd_data;
    end else begin
      stats_old = '0;
    end
    stats_new.frames   = sat_inc(stats_old.frames);
    stats_new.total    = sat_add_u(stats_old.total, {{(SUM_W-TICK_W){1'b0}}, a_item.ticks});
    stats_new.sq_total = sat_add_u(stats_old.sq_total,
                                   {{(SUM_W-SQ_W){1'b0}}, a_item.ticks_sq});
    stats_out = a_item.counted ? stats_new : stats_old;

    diff_neg = -a_item.diff;
    mag      = a_item.diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : a_item.diff[MAG_W-1:0];

    if (a_valid && a_item.done) begin
      paired_sum_next    = sat_add_s(paired_sum,
                             {{(SUM_W-DIFF_W){a_item.diff[DIFF_W-1]}}, a_item.diff});
      paired_groups_next = sat_inc(paired_groups);
    end else begin
      paired_sum_next    = paired_sum;
      paired_groups_next = paired_groups;
    end

    paired_sq_sum_next = (c_valid && c_res.group_done)
                         ? sat_add_u(paired_sq_sum, {{(SUM_W-DSQ_W){1'b0}}, c_dsq})
                         : paired_sq_sum;

    push_valid = c_valid;
    push_data  = c_res;
    push_data.group_diff_square_total = paired_sq_sum_next;
  end

  // Track written arms, bypass and paired sums
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_vld       <= '0;
      byp_valid     <= 1'b0;
      paired_sum    <= '0;
      paired_groups <= '0;
      paired_sq_sum <= '0;
      c_valid       <= 1'b0;
    end else begin
      byp_valid     <= wr_en;
      c_valid       <= a_valid;
      paired_sum    <= paired_sum_next;
      paired_groups <= paired_groups_next;
      paired_sq_sum <= paired_sq_sum_next;
      if (wr_en) begin
        arm_vld[a_item.arm] <= 1'b1;
      end
    end
  end

  // Hold read-side valid, bypass data and the second stage payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= arm_vld[rd_arm];
    end
    byp_arm  <= a_item.arm;
    byp_data <= stats_new;
    if (a_valid) begin
      c_res.arm_used                <= a_item.arm;
      c_res.next_arm                <= a_item.next_arm;
      c_res.counted                 <= a_item.counted;
      c_res.stats                   <= stats_out;
      c_res.group_done              <= a_item.done;
      c_res.group_diff_doubled      <= a_item.diff;
      c_res.group_count             <= paired_groups_next;
      c_res.group_diff_total        <= paired_sum_next;
      c_res.group_diff_square_total <= '0;
      c_dsq                         <= {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};
    end
  end

  a_groups_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_item.done |=> paired_groups == $past(paired_groups))
    else $error("group count moved without a completed group");

  a_diff_zero: assert property (@(posedge clk) disable iff (rst)
    c_valid && !c_res.group_done |-> c_res.group_diff_doubled == '0)
    else $error("difference reported without a completed group");

endmodule

// ===== design/apts_outq.sv =====
// Output queue of result beats, four deep, decoupling the pipeline from
// the downstream stall. Depends on apts_pkg.
module apts_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push_valid,
  input  apts_pkg::result_t             push_data,
  input  logic                          pop,
  output logic                          out_valid,
  output apts_pkg::result_t             out_data,
  output logic [apts_pkg::OUTQ_CW-1:0]  count
);
  import apts_pkg::*;

  result_t             q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  wr_ptr;
  logic [OUTQ_AW-1:0]  rd_ptr;

  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + OUTQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      count <= count + OUTQ_CW'(push_valid) - OUTQ_CW'(pop);
    end
  end

  // Store incoming beat
  always_ff @(posedge clk) begin
    if (push_valid) begin
      q[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (count < OUTQ_CW'(OUTQ_DEPTH)) || pop)
    else $error("output queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("output queue count out of range");

endmodule

// ===== design/abba_paired_timing_stats_unit.sv =====
// A result beat is registered by the front stage, then by the accumulate
// stage, then written into the output queue before it shows on the outputs.
// Throughput: one frame per cycle; the per-arm stats RAM is read at accept
// and written back in the next cycle, with a bypass for back-to-back frames.
// Input stalls only when the four-beat output queue could fill.
// Reset: synchronous; counters, sums and config go to defaults (warmup 30 groups).
module abba_paired_timing_stats_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [apts_pkg::TICK_W-1:0]          frame_ticks,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 arm_used,
  output logic                                 next_arm,
  output logic                                 counted,
  output logic [apts_pkg::FRAME_W-1:0]         arm_frames,
  output logic [apts_pkg::SUM_W-1:0]           arm_total,
  output logic [apts_pkg::SUM_W-1:0]           arm_square_total,
  output logic                                 group_done,
  output logic signed [apts_pkg::DIFF_W-1:0]   group_diff_doubled,
  output logic [apts_pkg::FRAME_W-1:0]         group_count,
  output logic signed [apts_pkg::SUM_W-1:0]    group_diff_total,
  output logic [apts_pkg::SUM_W-1:0]           group_diff_square_total,
  input  logic                                 cfg_wr_en,
  input  logic [apts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apts_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import apts_pkg::*;

  logic                 enable;
  logic                 swap_arms;
  logic [WARM_W-1:0]    warmup_groups;
  logic                 accept;
  logic                 pop;
  logic                 rd_arm;
  logic                 a_valid;
  item_t                a_item;
  logic                 push_valid;
  result_t              push_data;
  result_t              out_data;
  logic [OUTQ_CW-1:0]   occ;
  logic [OUTQ_CW-1:0]   inflight;

  // Handshakes; stall when queue plus in-flight beats could fill it
  always_comb begin
    inflight = occ + OUTQ_CW'(a_valid) + OUTQ_CW'(push_valid);
    in_stall = (inflight >= OUTQ_CW'(OUTQ_DEPTH));
    accept   = in_valid && !in_stall;
    pop      = out_valid && !out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      swap_arms     <= 1'b0;
      warmup_groups <= WARMUP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE: enable        <= cfg_data[0];
        REG_SWAP:   swap_arms     <= cfg_data[0];
        REG_WARMUP: warmup_groups <= cfg_data[WARM_W-1:0];
        default:    ;
      endcase
    end
  end

  apts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .frame_ticks   (frame_ticks),
    .enable        (enable),
    .swap_arms     (swap_arms),
    .warmup_groups (warmup_groups),
    .rd_arm        (rd_arm),
    .a_valid       (a_valid),
    .a_item        (a_item)
  );

  apts_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_arm     (rd_arm),
    .a_valid    (a_valid),
    .a_item     (a_item),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  apts_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .count      (occ)
  );

  // Unpack result beat
  always_comb begin
    arm_used                = out_data.arm_used;
    next_arm                = out_data.next_arm;
    counted                 = out_data.counted;
    arm_frames              = out_data.stats.frames;
    arm_total               = out_data.stats.total;
    arm_square_total        = out_data.stats.sq_total;
    group_done              = out_data.group_done;
    group_diff_doubled      = out_data.group_diff_doubled;
    group_count             = out_data.group_count;
    group_diff_total        = out_data.group_diff_total;
    group_diff_square_total = out_data.group_diff_square_total;
  end

endmodule
